/* sv/bbmf_pkg.sv */
// Shared constants, types and control structs of the block biquad matrix filter.
`default_nettype none

package bbmf_pkg;

  // Block geometry and number formats
  localparam int BLOCK_LEN  = 8;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 24;
  localparam int HIST_ROWS  = 4;
  localparam int ROWS       = HIST_ROWS + BLOCK_LEN;
  localparam int DEPTH      = ROWS * BLOCK_LEN;
  localparam int IDX_W      = 7;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int LANE_W     = $clog2(BLOCK_LEN);
  localparam int CNT_W      = $clog2(ROWS + 2);
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + $clog2(ROWS);
  localparam int FRAC_SHIFT = COEF_W - 4;

  // Stream widths
  localparam int S_FIELDS_W = IDX_W + COEF_W + BLOCK_LEN * SAMPLE_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((BLOCK_LEN * SAMPLE_W + 7) / 8) * 8;

  // Item kinds carried on tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             coef_write;
    logic             start;
    logic             issue;
    logic [ROW_W-1:0] row;
    logic             finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

/* sv/bbmf_ctrl.sv */
// Sequencer of the block biquad matrix filter: accept, row issue, drain, finish.
`default_nettype none

module bbmf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  input  wire logic                s_op,
  output logic                     s_tready,
  input  wire bbmf_pkg::ctrl_stat_t stat,
  output bbmf_pkg::ctrl_cmd_t      cmd
);

  bbmf_pkg::state_t                state, state_next;
  logic [bbmf_pkg::CNT_W-1:0]      cnt, cnt_next;
  logic                            accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbmf_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and row counter
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      bbmf_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (accept && s_op == bbmf_pkg::OP_FILTER) begin
          state_next = bbmf_pkg::ST_RUN;
        end
      end
      bbmf_pkg::ST_RUN: begin
        // run until the last product has entered the accumulators
        if (cnt == bbmf_pkg::CNT_W'(bbmf_pkg::ROWS + 1)) begin
          state_next = bbmf_pkg::ST_FINISH;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bbmf_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          state_next = bbmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bbmf_pkg::ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  // Outputs
  always_comb begin
    s_tready       = 1'b0;
    cmd.coef_write = 1'b0;
    cmd.start      = 1'b0;
    cmd.issue      = 1'b0;
    cmd.row        = cnt[bbmf_pkg::ROW_W-1:0];
    cmd.finish     = 1'b0;
    unique case (state)
      bbmf_pkg::ST_IDLE: begin
        s_tready       = 1'b1;
        cmd.coef_write = s_tvalid && s_op == bbmf_pkg::OP_WRITE;
        cmd.start      = s_tvalid && s_op == bbmf_pkg::OP_FILTER;
      end
      bbmf_pkg::ST_RUN: begin
        cmd.issue = cnt < bbmf_pkg::CNT_W'(bbmf_pkg::ROWS);
      end
      bbmf_pkg::ST_FINISH: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/bbmf_datapath.sv */
// Coefficient memory, history, eight MAC lanes and output register of the filter.
`default_nettype none

module bbmf_datapath (
  input  wire logic                                            clk,
  input  wire logic                                            rst,
  input  wire bbmf_pkg::ctrl_cmd_t                             cmd,
  output bbmf_pkg::ctrl_stat_t                                 stat,
  input  wire logic [bbmf_pkg::IDX_W-1:0]                      coef_index,
  input  wire logic [bbmf_pkg::COEF_W-1:0]                     coef_value,
  input  wire logic [bbmf_pkg::BLOCK_LEN-1:0][bbmf_pkg::SAMPLE_W-1:0] x_in,
  output logic                                                 m_tvalid,
  input  wire logic                                            m_tready,
  output logic [bbmf_pkg::M_TDATA_W-1:0]                       m_tdata
);

  localparam int SW  = bbmf_pkg::SAMPLE_W;
  localparam int CW  = bbmf_pkg::COEF_W;
  localparam int BL  = bbmf_pkg::BLOCK_LEN;
  localparam int RW  = bbmf_pkg::ROW_W;
  localparam int AW  = bbmf_pkg::ACC_W;
  localparam int PW  = bbmf_pkg::PROD_W;
  localparam int IW  = bbmf_pkg::IDX_W;
  localparam int LW  = bbmf_pkg::LANE_W;
  localparam int RND_W = AW + 1;
  localparam int SH_W  = RND_W - bbmf_pkg::FRAC_SHIFT;

  localparam logic [RW-1:0] ROW_Y_OLD = RW'(0);
  localparam logic [RW-1:0] ROW_Y_NEW = RW'(1);
  localparam logic [RW-1:0] ROW_X_OLD = RW'(2);
  localparam logic [RW-1:0] ROW_X_NEW = RW'(3);

  // Coefficient memory, one row per read, per-lane write
  logic [CW-1:0]       coef_mem [bbmf_pkg::ROWS][BL];
  logic [BL-1:0]       coef_vld [bbmf_pkg::ROWS];

  logic [IW-1:0]       wr_row_full;
  logic [IW-1:0]       wr_lane_full;
  logic                wr_ok;

  logic [CW-1:0]       rd_data [BL];
  logic [BL-1:0]       rd_vld;
  logic [RW-1:0]       rd_row;
  logic                rd_valid;

  logic signed [SW-1:0] x_q [BL];
  logic signed [SW-1:0] y_old, y_new, x_old, x_new;

  logic [RW-1:0]        xi_full;
  logic signed [SW-1:0] v_sel;
  logic signed [CW-1:0] coef_k [BL];

  logic signed [PW-1:0] prod [BL];
  logic                 prod_valid;
  logic signed [AW-1:0] acc [BL];

  logic signed [SW-1:0] y_sat [BL];
  logic signed [SW-1:0] y_q [BL];
  logic                 out_vld;

  function automatic logic signed [SW-1:0] round_sat(input logic signed [AW-1:0] a);
    logic signed [RND_W-1:0] biased;
    logic signed [SH_W-1:0]  sh;
    logic signed [SW-1:0]    res;
    biased = RND_W'(a) + (RND_W'(1) <<< (bbmf_pkg::FRAC_SHIFT - 1));
    sh     = SH_W'(biased >>> bbmf_pkg::FRAC_SHIFT);
    if (sh > SH_W'((1 << (SW - 1)) - 1)) begin
      res = {1'b0, {(SW-1){1'b1}}};
    end else if (sh < -SH_W'(1 << (SW - 1))) begin
      res = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res = sh[SW-1:0];
    end
    return res;
  endfunction

  assign wr_row_full  = coef_index / IW'(BL);
  assign wr_lane_full = coef_index % IW'(BL);
  assign wr_ok        = coef_index < IW'(bbmf_pkg::DEPTH);

  // Write one coefficient
  always_ff @(posedge clk) begin
    if (cmd.coef_write && wr_ok) begin
      coef_mem[wr_row_full[RW-1:0]][wr_lane_full[LW-1:0]] <= coef_value;
    end
  end

  // Entry valid bits; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < bbmf_pkg::ROWS; r++) begin
        coef_vld[r] <= '0;
      end
    end else if (cmd.coef_write && wr_ok) begin
      coef_vld[wr_row_full[RW-1:0]][wr_lane_full[LW-1:0]] <= 1'b1;
    end
  end

  // Registered row read
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      for (int k = 0; k < BL; k++) begin
        rd_data[k] <= coef_mem[cmd.row][k];
      end
      rd_vld <= coef_vld[cmd.row];
      rd_row <= cmd.row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= cmd.issue;
      prod_valid <= rd_valid;
    end
  end

  // Samples of the current block
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int k = 0; k < BL; k++) begin
        x_q[k] <= x_in[k];
      end
    end
  end

  // History of the last two outputs and inputs
  always_ff @(posedge clk) begin
    if (rst) begin
      y_old <= '0;
      y_new <= '0;
      x_old <= '0;
      x_new <= '0;
    end else if (cmd.finish) begin
      y_old <= y_sat[BL-2];
      y_new <= y_sat[BL-1];
      x_old <= x_q[BL-2];
      x_new <= x_q[BL-1];
    end
  end

  // Select the vector entry of the row being multiplied
  assign xi_full = rd_row - RW'(bbmf_pkg::HIST_ROWS);

  always_comb begin
    priority if (rd_row == ROW_Y_OLD) begin
      v_sel = y_old;
    end else if (rd_row == ROW_Y_NEW) begin
      v_sel = y_new;
    end else if (rd_row == ROW_X_OLD) begin
      v_sel = x_old;
    end else if (rd_row == ROW_X_NEW) begin
      v_sel = x_new;
    end else begin
      v_sel = x_q[xi_full[LW-1:0]];
    end
  end

  always_comb begin
    for (int k = 0; k < BL; k++) begin
      coef_k[k] = rd_vld[k] ? $signed(rd_data[k]) : '0;
    end
  end

  // Multiply, then accumulate
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      for (int k = 0; k < BL; k++) begin
        prod[k] <= PW'(coef_k[k]) * PW'(v_sel);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < BL; k++) begin
      if (cmd.start) begin
        acc[k] <= '0;
      end else if (prod_valid) begin
        acc[k] <= acc[k] + AW'(prod[k]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < BL; k++) begin
      y_sat[k] = round_sat(acc[k]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      for (int k = 0; k < BL; k++) begin
        y_q[k] <= y_sat[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cmd.finish) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  assign stat.out_free = !out_vld || m_tready;
  assign m_tvalid      = out_vld;

  always_comb begin
    m_tdata = '0;
    for (int k = 0; k < BL; k++) begin
      m_tdata[k*SW +: SW] = y_q[k];
    end
  end

endmodule

`default_nettype wire

/* sv/block_biquad_matrix_filter_core.sv */
// Top level of the block biquad matrix filter: stream ports, sequencer and datapath.
`default_nettype none

// Second-order IIR section in block state-space form. Each filter item carries eight
// Q1.15 samples; the block forms v = [y(n-2), y(n-1), x(n-2), x(n-1), x0..x7] and
// returns y0..y7, where lane k sums coef[r*8+k] * v[r] over the twelve rows, rounds
// half up to Q1.15 and saturates. Coefficients (signed Q3.20, slot = row*8 + lane)
// are loaded by write items, one per item; slots 96..127 are dropped. After reset
// all coefficients read as zero and the history is zero; there is no clearing pass.
// Timing: a write item is stored as it is accepted. For a filter item, the coefficient
// memory delivers one row per cycle to eight parallel multiply-accumulate lanes,
// through all twelve rows; the read and multiply registers then drain, and the
// sums round into the output register. The next item is accepted in the cycle
// after that rounding, even while the result still waits on m_tready;
// a later filter item holds in its finish step until the output register is free.
module block_biquad_matrix_filter_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input items
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // coef_index[6:0], coef_value[30:7], x0[46:31], x1..x7 in 16-bit steps up
  // to x7[158:143], bit 159 zero
  input  wire logic [bbmf_pkg::S_TDATA_W-1:0] s_tdata,
  // op[0]: 0 writes one coefficient, 1 filters a block
  input  wire logic                           s_tuser,
  // Result items
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // y0[15:0], y1[31:16], ... y7[127:112]
  output logic [bbmf_pkg::M_TDATA_W-1:0]      m_tdata
);

  localparam int SW = bbmf_pkg::SAMPLE_W;
  localparam int IW = bbmf_pkg::IDX_W;
  localparam int CW = bbmf_pkg::COEF_W;
  localparam int X_LSB = IW + CW;

  bbmf_pkg::ctrl_cmd_t  cmd;
  bbmf_pkg::ctrl_stat_t stat;

  logic [IW-1:0]                                          coef_index;
  logic [CW-1:0]                                          coef_value;
  logic [bbmf_pkg::BLOCK_LEN-1:0][bbmf_pkg::SAMPLE_W-1:0] x_in;

  // Unpack the input item
  assign coef_index = s_tdata[IW-1:0];
  assign coef_value = s_tdata[IW +: CW];

  always_comb begin
    for (int k = 0; k < bbmf_pkg::BLOCK_LEN; k++) begin
      x_in[k] = s_tdata[X_LSB + k*SW +: SW];
    end
  end

  bbmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_op     (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bbmf_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .x_in       (x_in),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire
